// ===== design/ffha_pkg.sv =====
// Shared types, codes and command/status bundles for the first-fit heap allocator.
package ffha_pkg;

    // Field widths of the request and result items
    localparam int REQ_W  = 13;
    localparam int OFF_W  = 12;
    localparam int STAT_W = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_FIT   = 2'd2;

    // Request function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [REQ_W-1:0]  req_size;
        logic [OFF_W-1:0]  free_offset;
    } ffha_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  payload_offset;
    } ffha_out_t;

    // Operand of the byte-offset to word-index divider
    typedef enum logic [2:0] {
        DIV_ROUND,
        DIV_FREE,
        DIV_HEAD,
        DIV_NEXT,
        DIV_SPLIT
    } ffha_div_src_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              div_go;
        ffha_div_src_t     div_src;
        logic              set_bs;
        logic              rd_go;
        logic              rd_prev;
        logic              hidx_cap;
        logic              cap_v;
        logic              adv_h;
        logic              merge_acc;
        logic              wr_merge;
        logic              fit_hdr;
        logic              fit_tail;
        logic              free_wr;
        logic              res_set;
        logic              res_off_h;
        logic [STAT_W-1:0] res_code;
        logic              res_push;
    } ffha_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_free;
        logic size_bad;
        logic h_end;
        logic r_end;
        logic rd_pos;
        logic rd_lt_bs;
        logic merge_ge;
        logic split;
        logic free_ok;
    } ffha_stat_t;

endpackage

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator top level: controller plus header datapath.
//
// Manages a HEAP_BYTES heap as an implicit chain of WORD_BYTES headers (positive size =
// free, negative = allocated) kept in a header memory of HEAP_BYTES/WORD_BYTES
// words. One request is handled at a time; s_ready is high only while the block waits for
// a new item, and a finished result sits in an output register so the next item can be
// taken before it is consumed; a finished request waits while that register is still
// occupied. A free divides the offset into a word index, checks it, reads the header
// before it and writes that header back as free; an offset that fails the check is
// ignored. A rejected size sets its result in decode. An allocate rounds the size to
// whole words, then walks the headers from the start: each step checks for the end of
// the heap, forms the header index with the reciprocal-multiply stage and does a
// registered memory read. A free header that is too small is grown by a forward merge
// of the free headers that follow it; the chosen header is then written, with a split
// tail where space is left over, and the result is loaded. Header 0 is valid right after
// reset (one flag marks it as holding all usable space), so there is no clearing pass.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 4096,
    parameter int WORD_BYTES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffha_pkg::ffha_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ffha_pkg::ffha_out_t m_item
);
    import ffha_pkg::*;

    ffha_cmd_t  cmd;
    ffha_stat_t stat;

    // Sequence each request
    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold headers and walk state
    ffha_dp #(
        .HEAP_BYTES (HEAP_BYTES),
        .WORD_BYTES (WORD_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_item),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (m_item)
    );

endmodule

// ===== design/ffha_dp.sv =====
// Datapath of the heap allocator: header memory, walk registers and index divider.
module ffha_dp #(
    parameter int HEAP_BYTES = 4096,
    parameter int WORD_BYTES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ffha_pkg::ffha_in_t in_item,
    input  ffha_pkg::ffha_cmd_t cmd,
    output ffha_pkg::ffha_stat_t stat,
    output ffha_pkg::ffha_out_t out_item
);
    import ffha_pkg::*;

    localparam int DEPTH  = (HEAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int IW     = $clog2(DEPTH);
    localparam int OW     = $clog2(HEAP_BYTES) + 2;
    localparam int HW     = $clog2(HEAP_BYTES) + 2;
    localparam int DW     = (OW > REQ_W) ? OW : REQ_W;
    localparam int SHIFT  = DW + 3;
    localparam int MW     = DW + 2;
    localparam int PW     = DW + MW;
    localparam int USABLE = HEAP_BYTES - WORD_BYTES;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SHIFT) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES));
    localparam logic signed [HW-1:0] USABLE_HDR = HW'(USABLE);

    // Header store
    logic signed [HW-1:0] mem [DEPTH];

    // Request registers
    logic              func_reg;
    logic [REQ_W-1:0]  rs_reg;
    logic [OFF_W-1:0]  foff_reg;

    // Walk registers
    logic [DW-1:0]        quot_reg;
    logic [OW-1:0]        bs_reg;
    logic [OW-1:0]        h_reg;
    logic [OW-1:0]        r_reg;
    logic [OW-1:0]        sum_reg;
    logic signed [HW-1:0] v_reg;
    logic [IW-1:0]        hidx_reg;

    // Read port and header 0 valid bit
    logic signed [HW-1:0] rdata_reg;
    logic                 rd_zero_reg;
    logic                 hdr0_ok_reg;

    // Result registers
    logic [STAT_W-1:0] pend_status_reg;
    logic [OFF_W-1:0]  pend_off_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [OFF_W-1:0]  out_off_reg;

    logic [DW-1:0]        div_in;
    logic [PW-1:0]        div_prod;
    logic [DW-1:0]        quot_w;
    logic [OW-1:0]        bs_raw;
    logic [OW-1:0]        bs_adj;
    logic [IW-1:0]        rd_idx;
    logic signed [HW-1:0] rd_val;
    logic signed [OW:0]   rd_x;
    logic signed [OW:0]   v_x;
    logic signed [OW:0]   bs_x;
    logic [OW-1:0]        rd_mag;
    logic [OW-1:0]        v_mag;
    logic [OW-1:0]        sum_next;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic signed [HW-1:0] wr_data;

    // Divider operand and reciprocal multiply
    always_comb begin
        unique case (cmd.div_src)
            DIV_ROUND: div_in = DW'(rs_reg) + DW'(WORD_BYTES - 1);
            DIV_FREE:  div_in = DW'(foff_reg);
            DIV_HEAD:  div_in = DW'(h_reg);
            DIV_NEXT:  div_in = DW'(r_reg);
            DIV_SPLIT: div_in = DW'(h_reg + OW'(WORD_BYTES) + bs_reg);
            default:   div_in = DW'(h_reg);
        endcase
    end

    assign div_prod = PW'(div_in) * PW'(RECIP);
    assign quot_w   = quot_reg * DW'(WORD_BYTES);

    // Round the size to whole words, take all space on a tiny remainder
    assign bs_raw = OW'(quot_w);
    assign bs_adj = ((bs_raw <= OW'(USABLE)) && (bs_raw + OW'(WORD_BYTES) >= OW'(USABLE)))
                    ? OW'(USABLE) : bs_raw;

    // Header read value and derived magnitudes
    assign rd_idx = cmd.rd_prev ? IW'(quot_reg - DW'(1)) : quot_reg[IW-1:0];
    assign rd_val = rd_zero_reg ? USABLE_HDR : rdata_reg;
    assign rd_x   = (OW+1)'(rd_val);
    assign v_x    = (OW+1)'(v_reg);
    assign bs_x   = signed'({1'b0, bs_reg});
    assign rd_mag = (rd_x < 0) ? OW'(-rd_x) : OW'(rd_x);
    assign v_mag  = (v_x < 0) ? OW'(-v_x) : OW'(v_x);
    assign sum_next = sum_reg + rd_mag + OW'(WORD_BYTES);

    // Status toward the controller
    always_comb begin
        stat.is_free  = (func_reg == FUNC_FREE);
        stat.size_bad = (rs_reg == '0) || (rs_reg > USABLE);
        stat.h_end    = (h_reg >= HEAP_BYTES);
        stat.r_end    = (r_reg >= HEAP_BYTES);
        stat.rd_pos   = (rd_x > 0);
        stat.rd_lt_bs = (rd_x < bs_x);
        stat.merge_ge = (sum_next >= bs_reg);
        stat.split    = ((v_x - bs_x) > WORD_BYTES);
        stat.free_ok  = (foff_reg >= WORD_BYTES) && (DW'(foff_reg) == quot_w)
                        && (quot_reg <= DEPTH);
    end

    // Select the single write of this cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = hidx_reg;
        wr_data = rd_val;
        priority if (cmd.wr_merge && stat.merge_ge) begin
            wr_en   = 1'b1;
            wr_data = HW'(sum_next);
        end else if (cmd.fit_hdr) begin
            wr_en   = 1'b1;
            wr_data = stat.split ? HW'(-bs_x) : HW'(-v_x);
        end else if (cmd.fit_tail) begin
            wr_en   = (quot_reg < DEPTH);
            wr_idx  = quot_reg[IW-1:0];
            wr_data = HW'(v_x - bs_x - (OW+1)'(WORD_BYTES));
        end else if (cmd.free_wr) begin
            wr_en   = 1'b1;
            wr_data = HW'(rd_mag);
        end
    end

    // Header memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.rd_go) begin
            rdata_reg   <= mem[rd_idx];
            rd_zero_reg <= (rd_idx == '0) && !hdr0_ok_reg;
        end
    end

    // Header 0 holds all usable space until its first write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr0_ok_reg <= 1'b0;
        end else if (wr_en && (wr_idx == '0)) begin
            hdr0_ok_reg <= 1'b1;
        end
    end

    // Request, walk and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_item.func;
            rs_reg   <= in_item.req_size;
            foff_reg <= in_item.free_offset;
        end
        if (cmd.div_go) begin
            quot_reg <= DW'(div_prod >> SHIFT);
        end
        if (cmd.set_bs) begin
            bs_reg <= bs_adj;
            h_reg  <= '0;
        end
        if (cmd.hidx_cap) begin
            hidx_reg <= rd_idx;
        end
        if (cmd.cap_v) begin
            v_reg   <= rd_val;
            sum_reg <= rd_mag;
            r_reg   <= h_reg + OW'(WORD_BYTES) + rd_mag;
        end
        if (cmd.adv_h) begin
            h_reg <= h_reg + OW'(WORD_BYTES) + v_mag;
        end
        if (cmd.merge_acc) begin
            sum_reg <= sum_next;
            r_reg   <= r_reg + OW'(WORD_BYTES) + rd_mag;
            if (stat.merge_ge) begin
                v_reg <= HW'(sum_next);
            end
        end
        if (cmd.res_set) begin
            pend_status_reg <= cmd.res_code;
            pend_off_reg    <= cmd.res_off_h ? OFF_W'(h_reg + OW'(WORD_BYTES)) : '0;
        end
        if (cmd.res_push) begin
            out_status_reg <= pend_status_reg;
            out_off_reg    <= pend_off_reg;
        end
    end

    assign out_item.status         = out_status_reg;
    assign out_item.payload_offset = out_off_reg;

endmodule

// ===== design/ffha_ctrl.sv =====
// Controller of the heap allocator: sequences decode, header walk, merge, split and free.
module ffha_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ffha_pkg::ffha_stat_t stat,
    output ffha_pkg::ffha_cmd_t  cmd
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        DECODE,
        SET_BS,
        WALK_CHK,
        WALK_RD,
        WALK_EVAL,
        WALK_ADV,
        MERGE_CHK,
        MERGE_RD,
        MERGE_EVAL,
        FIT,
        FIT_TAIL,
        FREE_CHK,
        FREE_WR,
        DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_src = DIV_HEAD;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = DECODE;
                end
            end
            DECODE: begin
                priority if (stat.is_free) begin
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_FREE;
                    state_next  = FREE_CHK;
                end else if (stat.size_bad) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_BAD_SIZE;
                    state_next   = DONE;
                end else begin
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_ROUND;
                    state_next  = SET_BS;
                end
            end
            SET_BS: begin
                cmd.set_bs = 1'b1;
                state_next = WALK_CHK;
            end
            WALK_CHK: begin
                if (stat.h_end) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_NO_FIT;
                    state_next   = DONE;
                end else begin
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_HEAD;
                    state_next  = WALK_RD;
                end
            end
            WALK_RD: begin
                cmd.rd_go    = 1'b1;
                cmd.hidx_cap = 1'b1;
                state_next   = WALK_EVAL;
            end
            WALK_EVAL: begin
                cmd.cap_v = 1'b1;
                priority if (stat.rd_pos && stat.rd_lt_bs) begin
                    state_next = MERGE_CHK;
                end else if (!stat.rd_lt_bs) begin
                    state_next = FIT;
                end else begin
                    state_next = WALK_ADV;
                end
            end
            WALK_ADV: begin
                cmd.adv_h  = 1'b1;
                state_next = WALK_CHK;
            end
            MERGE_CHK: begin
                if (stat.r_end) begin
                    state_next = WALK_ADV;
                end else begin
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_NEXT;
                    state_next  = MERGE_RD;
                end
            end
            MERGE_RD: begin
                cmd.rd_go  = 1'b1;
                state_next = MERGE_EVAL;
            end
            MERGE_EVAL: begin
                priority if (!stat.rd_pos) begin
                    state_next = WALK_ADV;
                end else if (stat.merge_ge) begin
                    cmd.merge_acc = 1'b1;
                    cmd.wr_merge  = 1'b1;
                    state_next    = FIT;
                end else begin
                    cmd.merge_acc = 1'b1;
                    state_next    = MERGE_CHK;
                end
            end
            FIT: begin
                cmd.fit_hdr = 1'b1;
                if (stat.split) begin
                    cmd.div_go  = 1'b1;
                    cmd.div_src = DIV_SPLIT;
                    state_next  = FIT_TAIL;
                end else begin
                    cmd.res_set   = 1'b1;
                    cmd.res_off_h = 1'b1;
                    cmd.res_code  = STAT_OK;
                    state_next    = DONE;
                end
            end
            FIT_TAIL: begin
                cmd.fit_tail  = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_off_h = 1'b1;
                cmd.res_code  = STAT_OK;
                state_next    = DONE;
            end
            FREE_CHK: begin
                if (stat.free_ok) begin
                    cmd.rd_go    = 1'b1;
                    cmd.rd_prev  = 1'b1;
                    cmd.hidx_cap = 1'b1;
                    state_next   = FREE_WR;
                end else begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_OK;
                    state_next   = DONE;
                end
            end
            FREE_WR: begin
                cmd.free_wr  = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = STAT_OK;
                state_next   = DONE;
            end
            DONE: begin
                if (out_free) begin
                    cmd.res_push = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // Output item valid: set on push, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.res_push) begin
            m_valid_next = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
